FILE: design/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg
// Shared types and constants for the planet gravity acceleration block.
// ----------------------------------------------------------------------------
package pga_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_PLANET_COUNT = 1'b0;
    localparam logic REG_GRAV_CONST   = 1'b1;

    localparam logic [15:0] GRAV_CONST_RESET = 16'd2000;

    localparam int SQRT_STEPS = 32;
    localparam int MAG_STEPS  = 32;
    localparam int UNIT_STEPS = 62;

    localparam logic signed [39:0] ACC_MAX = 40'sh007FFFFFFF;
    localparam logic signed [39:0] ACC_MIN = 40'shFF80000000;
    localparam logic signed [31:0] OUT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh80000000;

    typedef logic [4:0] cmd_code_t;

    localparam cmd_code_t CMD_NONE      = 5'd0;
    localparam cmd_code_t CMD_WRITE     = 5'd1;
    localparam cmd_code_t CMD_START     = 5'd2;
    localparam cmd_code_t CMD_READ      = 5'd3;
    localparam cmd_code_t CMD_DIFF      = 5'd4;
    localparam cmd_code_t CMD_SQX       = 5'd5;
    localparam cmd_code_t CMD_SQY       = 5'd6;
    localparam cmd_code_t CMD_R2        = 5'd7;
    localparam cmd_code_t CMD_COIN      = 5'd8;
    localparam cmd_code_t CMD_GM        = 5'd9;
    localparam cmd_code_t CMD_SQRT_STEP = 5'd10;
    localparam cmd_code_t CMD_MAG_LOAD  = 5'd11;
    localparam cmd_code_t CMD_DIV_STEP  = 5'd12;
    localparam cmd_code_t CMD_MAG_STORE = 5'd13;
    localparam cmd_code_t CMD_UX_LOAD   = 5'd14;
    localparam cmd_code_t CMD_UX_STORE  = 5'd15;
    localparam cmd_code_t CMD_UY_LOAD   = 5'd16;
    localparam cmd_code_t CMD_UY_STORE  = 5'd17;
    localparam cmd_code_t CMD_MULX      = 5'd18;
    localparam cmd_code_t CMD_ACCX      = 5'd19;
    localparam cmd_code_t CMD_MULY      = 5'd20;
    localparam cmd_code_t CMD_ACCY      = 5'd21;
    localparam cmd_code_t CMD_NEXT      = 5'd22;
    localparam cmd_code_t CMD_OUT       = 5'd23;

    typedef struct packed {
        cmd_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic r2_zero;
        logic last_body;
        logic empty;
    } dp_status_t;

endpackage

FILE: design/planet_gravity_acceleration.sv
// ----------------------------------------------------------------------------
// planet_gravity_acceleration
// 2D direct-sum gravitational acceleration over a table of bodies.
// ----------------------------------------------------------------------------
// A write transfer (op 0) stores one body. A query transfer (op 1) visits
// N = min(planet_count, MAX_PLANETS) bodies; a body sitting at the probe
// skips the square root and the divisions. Per body the time is set by a
// 32-step bit-serial square root and one shared bit-serial divider: a 32-step
// magnitude division and two 62-step unit-vector divisions. A finished result
// waits in the output register while a new item may already be taken.
module planet_gravity_acceleration
    import pga_pkg::*;
#(
    parameter int MAX_PLANETS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [3:0]         s_entry_index,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic [23:0]        s_body_mass,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_accel_x,
    output logic signed [31:0] m_accel_y,
    output logic               m_saturated,
    output logic               m_coincident,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data
);

    logic [4:0]  planet_count_reg;
    logic [15:0] grav_const_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planet_count_reg <= '0;
            grav_const_reg   <= GRAV_CONST_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PLANET_COUNT: planet_count_reg <= cfg_wr_data[4:0];
                REG_GRAV_CONST:   grav_const_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    pga_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    pga_datapath #(
        .MAX_PLANETS (MAX_PLANETS)
    ) u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .status       (status),
        .entry_index  (s_entry_index),
        .pos_x        (s_pos_x),
        .pos_y        (s_pos_y),
        .body_mass    (s_body_mass),
        .planet_count (planet_count_reg),
        .grav_const   (grav_const_reg),
        .accel_x      (m_accel_x),
        .accel_y      (m_accel_y),
        .saturated    (m_saturated),
        .coincident   (m_coincident)
    );

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_WRITE |=> !$rose(m_valid))
        else $error("write transfer produced a result");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_QUERY |=> !s_ready)
        else $error("query did not occupy the block");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_accel_x == OUT_MAX || m_accel_x == OUT_MIN ||
            m_accel_y == OUT_MAX || m_accel_y == OUT_MIN)
        else $error("saturated flag without a clipped sum");
`endif

endmodule

FILE: design/pga_ctrl.sv
// ----------------------------------------------------------------------------
// pga_ctrl
// Sequencer: handshakes and the per-body command schedule for the datapath.
// ----------------------------------------------------------------------------
module pga_ctrl
    import pga_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_op,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CHKN   = 5'd1;
    localparam logic [4:0] ST_READ   = 5'd2;
    localparam logic [4:0] ST_DIFF   = 5'd3;
    localparam logic [4:0] ST_SQX    = 5'd4;
    localparam logic [4:0] ST_SQY    = 5'd5;
    localparam logic [4:0] ST_R2     = 5'd6;
    localparam logic [4:0] ST_CHKR   = 5'd7;
    localparam logic [4:0] ST_SQRT   = 5'd8;
    localparam logic [4:0] ST_MAGLD  = 5'd9;
    localparam logic [4:0] ST_MAGDIV = 5'd10;
    localparam logic [4:0] ST_MAGST  = 5'd11;
    localparam logic [4:0] ST_UXLD   = 5'd12;
    localparam logic [4:0] ST_UXDIV  = 5'd13;
    localparam logic [4:0] ST_UXST   = 5'd14;
    localparam logic [4:0] ST_UYLD   = 5'd15;
    localparam logic [4:0] ST_UYDIV  = 5'd16;
    localparam logic [4:0] ST_UYST   = 5'd17;
    localparam logic [4:0] ST_MULX   = 5'd18;
    localparam logic [4:0] ST_ACCX   = 5'd19;
    localparam logic [4:0] ST_MULY   = 5'd20;
    localparam logic [4:0] ST_ACCY   = 5'd21;
    localparam logic [4:0] ST_NEXT   = 5'd22;
    localparam logic [4:0] ST_DONE   = 5'd23;

    localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);
    localparam logic [5:0] MAG_LAST  = 6'(MAG_STEPS - 1);
    localparam logic [5:0] UNIT_LAST = 6'(UNIT_STEPS - 1);

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.code     = CMD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_QUERY) begin
                        cmd.code   = CMD_START;
                        state_next = ST_CHKN;
                    end else begin
                        cmd.code = CMD_WRITE;
                    end
                end
            end
            ST_CHKN:  state_next = status.empty ? ST_DONE : ST_READ;
            ST_READ: begin
                cmd.code   = CMD_READ;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.code   = CMD_DIFF;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                cmd.code   = CMD_SQX;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.code   = CMD_SQY;
                state_next = ST_R2;
            end
            ST_R2: begin
                cmd.code   = CMD_R2;
                state_next = ST_CHKR;
            end
            ST_CHKR: begin
                cnt_next = '0;
                if (status.r2_zero) begin
                    cmd.code   = CMD_COIN;
                    state_next = ST_NEXT;
                end else begin
                    cmd.code   = CMD_GM;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.code = CMD_SQRT_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_MAGLD;
                end
            end
            ST_MAGLD: begin
                cmd.code   = CMD_MAG_LOAD;
                cnt_next   = '0;
                state_next = ST_MAGDIV;
            end
            ST_MAGDIV: begin
                cmd.code = CMD_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MAG_LAST) begin
                    state_next = ST_MAGST;
                end
            end
            ST_MAGST: begin
                cmd.code   = CMD_MAG_STORE;
                state_next = ST_UXLD;
            end
            ST_UXLD: begin
                cmd.code   = CMD_UX_LOAD;
                cnt_next   = '0;
                state_next = ST_UXDIV;
            end
            ST_UXDIV: begin
                cmd.code = CMD_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == UNIT_LAST) begin
                    state_next = ST_UXST;
                end
            end
            ST_UXST: begin
                cmd.code   = CMD_UX_STORE;
                state_next = ST_UYLD;
            end
            ST_UYLD: begin
                cmd.code   = CMD_UY_LOAD;
                cnt_next   = '0;
                state_next = ST_UYDIV;
            end
            ST_UYDIV: begin
                cmd.code = CMD_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == UNIT_LAST) begin
                    state_next = ST_UYST;
                end
            end
            ST_UYST: begin
                cmd.code   = CMD_UY_STORE;
                state_next = ST_MULX;
            end
            ST_MULX: begin
                cmd.code   = CMD_MULX;
                state_next = ST_ACCX;
            end
            ST_ACCX: begin
                cmd.code   = CMD_ACCX;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                cmd.code   = CMD_MULY;
                state_next = ST_ACCY;
            end
            ST_ACCY: begin
                cmd.code   = CMD_ACCY;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                cmd.code   = CMD_NEXT;
                state_next = status.last_body ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.code     = CMD_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/pga_datapath.sv
// ----------------------------------------------------------------------------
// pga_datapath
// Body table, shared multiplier, iterative square root and divider,
// accumulators and saturating output registers.
// ----------------------------------------------------------------------------
module pga_datapath
    import pga_pkg::*;
#(
    parameter int MAX_PLANETS = 16
) (
    input  logic               aclk,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [3:0]         entry_index,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic [23:0]        body_mass,
    input  logic [4:0]         planet_count,
    input  logic [15:0]        grav_const,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic               saturated,
    output logic               coincident
);

    localparam int IDX_W = (MAX_PLANETS > 1) ? $clog2(MAX_PLANETS) : 1;
    localparam int CNT_W = $clog2(MAX_PLANETS + 1);

    // body table: {x, y, mass}
    logic [71:0] mem [MAX_PLANETS];
    logic [71:0] rd_reg;
    logic        wr_ok;

    logic [CNT_W-1:0] ptr_reg, n_reg;
    logic signed [23:0] px_reg, py_reg;

    logic signed [24:0] dx, dy;
    logic [24:0] ax_reg, ay_reg;
    logic        dx_neg_reg, dy_neg_reg;
    logic [49:0] r2_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;

    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg, sq_sum;

    logic [49:0] div_rem_reg, div_den_reg;
    logic [61:0] div_num_reg;
    logic [31:0] div_q_reg;
    logic [50:0] div_t;
    logic        div_ge;
    logic        cap_reg;

    logic [31:0] mag_reg, ux_reg, uy_reg;
    logic [39:0] cterm;
    logic signed [39:0] acc_x_reg, acc_y_reg;
    logic        coin_reg;

    logic signed [31:0] ax_out_reg, ay_out_reg;
    logic        sat_out_reg, coin_out_reg;
    logic        sat_x, sat_y;

    assign wr_ok = ({28'd0, entry_index} < 32'(MAX_PLANETS));

    always_ff @(posedge aclk) begin
        if (cmd.code == CMD_WRITE && wr_ok) begin
            mem[IDX_W'(entry_index)] <= {pos_x, pos_y, body_mass};
        end
        if (cmd.code == CMD_READ) begin
            rd_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    assign dx = 25'(signed'(rd_reg[71:48])) - 25'(px_reg);
    assign dy = 25'(signed'(rd_reg[47:24])) - 25'(py_reg);

    assign status.r2_zero   = (r2_reg == '0);
    assign status.last_body = ((ptr_reg + CNT_W'(1)) == n_reg);
    assign status.empty     = (n_reg == '0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.code)
            CMD_SQX: begin
                mul_a = {7'd0, ax_reg};
                mul_b = {7'd0, ax_reg};
            end
            CMD_SQY: begin
                mul_a = {7'd0, ay_reg};
                mul_b = {7'd0, ay_reg};
            end
            CMD_GM: begin
                mul_a = {16'd0, grav_const};
                mul_b = {8'd0, rd_reg[23:0]};
            end
            CMD_MULX: begin
                mul_a = mag_reg;
                mul_b = ux_reg;
            end
            CMD_MULY: begin
                mul_a = mag_reg;
                mul_b = uy_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_sum = sq_res_reg + sq_bit_reg;
    assign div_t  = {div_rem_reg, div_num_reg[61]};
    assign div_ge = (div_t >= {1'b0, div_den_reg});
    assign cterm  = {6'd0, prod_reg[63:30]};

    assign sat_x = (acc_x_reg > ACC_MAX) || (acc_x_reg < ACC_MIN);
    assign sat_y = (acc_y_reg > ACC_MAX) || (acc_y_reg < ACC_MIN);

    always_ff @(posedge aclk) begin
        unique case (cmd.code)
            CMD_NONE, CMD_WRITE, CMD_READ: begin
            end
            CMD_START: begin
                px_reg    <= pos_x;
                py_reg    <= pos_y;
                ptr_reg   <= '0;
                n_reg     <= ({27'd0, planet_count} > 32'(MAX_PLANETS)) ?
                             CNT_W'(MAX_PLANETS) : CNT_W'(planet_count);
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                coin_reg  <= 1'b0;
            end
            CMD_DIFF: begin
                dx_neg_reg <= dx[24];
                dy_neg_reg <= dy[24];
                ax_reg     <= dx[24] ? 25'(-dx) : 25'(dx);
                ay_reg     <= dy[24] ? 25'(-dy) : 25'(dy);
            end
            CMD_SQX, CMD_MULX, CMD_MULY: begin
                prod_reg <= mul_a * mul_b;
            end
            CMD_SQY: begin
                prod_reg <= mul_a * mul_b;
                r2_reg   <= prod_reg[49:0];
            end
            CMD_R2: begin
                r2_reg <= r2_reg + prod_reg[49:0];
            end
            CMD_COIN: begin
                coin_reg <= 1'b1;
            end
            CMD_GM: begin
                prod_reg   <= mul_a * mul_b;
                sq_v_reg   <= {r2_reg, 14'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            CMD_SQRT_STEP: begin
                if (sq_v_reg >= sq_sum) begin
                    sq_v_reg   <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            CMD_MAG_LOAD: begin
                cap_reg     <= ({10'd0, prod_reg[39:0]} >= r2_reg);
                div_rem_reg <= {10'd0, prod_reg[39:0]};
                div_num_reg <= '0;
                div_den_reg <= r2_reg;
                div_q_reg   <= '0;
            end
            CMD_DIV_STEP: begin
                div_rem_reg <= div_ge ? 50'(div_t - {1'b0, div_den_reg}) : div_t[49:0];
                div_q_reg   <= {div_q_reg[30:0], div_ge};
                div_num_reg <= {div_num_reg[60:0], 1'b0};
            end
            CMD_MAG_STORE: begin
                mag_reg <= cap_reg ? '1 : div_q_reg;
            end
            CMD_UX_LOAD: begin
                div_rem_reg <= '0;
                div_num_reg <= {ax_reg, 37'd0};
                div_den_reg <= {18'd0, sq_res_reg[31:0]};
                div_q_reg   <= '0;
            end
            CMD_UX_STORE: begin
                ux_reg <= div_q_reg;
            end
            CMD_UY_LOAD: begin
                div_rem_reg <= '0;
                div_num_reg <= {ay_reg, 37'd0};
                div_den_reg <= {18'd0, sq_res_reg[31:0]};
                div_q_reg   <= '0;
            end
            CMD_UY_STORE: begin
                uy_reg <= div_q_reg;
            end
            CMD_ACCX: begin
                acc_x_reg <= dx_neg_reg ? acc_x_reg - signed'(cterm)
                                        : acc_x_reg + signed'(cterm);
            end
            CMD_ACCY: begin
                acc_y_reg <= dy_neg_reg ? acc_y_reg - signed'(cterm)
                                        : acc_y_reg + signed'(cterm);
            end
            CMD_NEXT: begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            CMD_OUT: begin
                ax_out_reg   <= (acc_x_reg > ACC_MAX) ? OUT_MAX :
                                (acc_x_reg < ACC_MIN) ? OUT_MIN : acc_x_reg[31:0];
                ay_out_reg   <= (acc_y_reg > ACC_MAX) ? OUT_MAX :
                                (acc_y_reg < ACC_MIN) ? OUT_MIN : acc_y_reg[31:0];
                sat_out_reg  <= sat_x || sat_y;
                coin_out_reg <= coin_reg;
            end
            default: begin
            end
        endcase
    end

    assign accel_x    = ax_out_reg;
    assign accel_y    = ay_out_reg;
    assign saturated  = sat_out_reg;
    assign coincident = coin_out_reg;

endmodule

FILE: bench/tb_planet_gravity_acceleration.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planet_gravity_acceleration
// Self-checking bench for the body table and direct-sum acceleration block.
// Body writes and probe queries go in over a valid/ready channel. A bit-exact
// fixed-point predictor models each query, and a scoreboard compares every
// result transfer with the oldest prediction. The run covers several
// count/constant settings, random stalls on both sides, a long receiver
// hold-off and full drains between settings.
// ----------------------------------------------------------------------------
module tb_planet_gravity_acceleration
    import pga_pkg::*;
();

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               saturated;
        logic               coincident;
    } accel_result_t;

    class gravity_scoreboard;
        logic signed [23:0] tab_x[TABLE_DEPTH];
        logic signed [23:0] tab_y[TABLE_DEPTH];
        logic [23:0]        tab_mass[TABLE_DEPTH];
        logic [4:0]         body_count = 5'd0;
        logic [15:0]        g_scale = GRAV_CONST_RESET;
        accel_result_t      pending_accel[$];
        int                 errors = 0;
        int                 results = 0;
        int                 n_coin = 0;
        int                 n_sat = 0;

        function void set_register(logic addr, logic [15:0] data);
            if (addr == REG_PLANET_COUNT) begin
                body_count = data[4:0];
            end else begin
                g_scale = data;
            end
        endfunction

        function int pending();
            return pending_accel.size();
        endfunction

        function bit [63:0] root_floor(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] trial;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v) res = trial;
            end
            return res;
        endfunction

        function void take_item(logic op, logic [3:0] idx, logic signed [23:0] px,
                                logic signed [23:0] py, logic [23:0] mass);
            accel_result_t e;
            int            n;
            longint        dx, dy, sum_x, sum_y;
            bit [63:0]     ax, ay, r2, root, ux, uy;
            bit [95:0]     gm, mag, cx, cy;
            if (op == OP_WRITE) begin
                tab_x[idx] = px;
                tab_y[idx] = py;
                tab_mass[idx] = mass;
                return;
            end
            n = (body_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(body_count);
            sum_x = 0;
            sum_y = 0;
            e.coincident = 1'b0;
            e.saturated = 1'b0;
            for (int i = 0; i < n; i++) begin
                dx = longint'(tab_x[i]) - longint'(px);
                dy = longint'(tab_y[i]) - longint'(py);
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                r2 = ax * ax + ay * ay;
                if (r2 == 0) begin
                    e.coincident = 1'b1;
                    continue;
                end
                root = root_floor(r2 << 14);
                gm = 96'(g_scale) * 96'(tab_mass[i]);
                mag = (gm << 32) / 96'(r2);
                if (mag > 96'hFFFF_FFFF) mag = 96'hFFFF_FFFF;
                ux = (ax << 37) / root;
                uy = (ay << 37) / root;
                cx = (mag * 96'(ux)) >> 30;
                cy = (mag * 96'(uy)) >> 30;
                sum_x += (dx < 0) ? -longint'(cx) : longint'(cx);
                sum_y += (dy < 0) ? -longint'(cy) : longint'(cy);
            end
            if (sum_x > 64'sd2147483647) begin
                sum_x = 64'sd2147483647; e.saturated = 1'b1;
            end else if (sum_x < -64'sd2147483648) begin
                sum_x = -64'sd2147483648; e.saturated = 1'b1;
            end
            if (sum_y > 64'sd2147483647) begin
                sum_y = 64'sd2147483647; e.saturated = 1'b1;
            end else if (sum_y < -64'sd2147483648) begin
                sum_y = -64'sd2147483648; e.saturated = 1'b1;
            end
            e.accel_x = sum_x[31:0];
            e.accel_y = sum_y[31:0];
            pending_accel = {pending_accel, e};
        endfunction

        function void check_result(accel_result_t got);
            accel_result_t e;
            results++;
            if (pending_accel.size() == 0) begin
                $display("%0t: result transfer with nothing pending: x=%0d y=%0d",
                         $time, got.accel_x, got.accel_y);
                errors++;
                return;
            end
            e = pending_accel.pop_front();
            if (e.coincident) n_coin++;
            if (e.saturated) n_sat++;
            if (got.accel_x !== e.accel_x) begin
                $display("%0t: accel_x expected %0d actual %0d", $time, e.accel_x, got.accel_x);
                errors++;
            end
            if (got.accel_y !== e.accel_y) begin
                $display("%0t: accel_y expected %0d actual %0d", $time, e.accel_y, got.accel_y);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                         got.saturated);
                errors++;
            end
            if (got.coincident !== e.coincident) begin
                $display("%0t: coincident expected %0b actual %0b", $time, e.coincident,
                         got.coincident);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [3:0]         s_entry_index;
    logic signed [23:0] s_pos_x;
    logic signed [23:0] s_pos_y;
    logic [23:0]        s_body_mass;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_accel_x;
    logic signed [31:0] m_accel_y;
    logic               m_saturated;
    logic               m_coincident;
    logic               cfg_wr_en;
    logic               cfg_addr;
    logic [15:0]        cfg_wr_data;

    gravity_scoreboard sb;
    bit   no_idle;
    bit   hold;
    event start_hold;
    int   stall_cycles;
    int   n_writes;
    int   n_queries;

    planet_gravity_acceleration dut (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // transfer monitor and stall watchdog
    always @(posedge aclk) begin
        accel_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.accel_x = m_accel_x;
                got.accel_y = m_accel_y;
                got.saturated = m_saturated;
                got.coincident = m_coincident;
                sb.check_result(got);
            end
            if (s_valid && s_ready) begin
                sb.take_item(s_op, s_entry_index, s_pos_x, s_pos_y, s_body_mass);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("planet_gravity_acceleration verification failed");
                    $finish;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold) begin
            m_ready = 1'b0;
        end else begin
            m_ready = no_idle || ($urandom_range(99) >= 21);
        end
    end

    initial begin
        hold = 1'b0;
        forever begin
            @(start_hold);
            hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge aclk);
            hold = 1'b0;
        end
    end

    task automatic write_reg(logic addr, logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wr_data = data;
        sb.set_register(addr, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_item(logic op, logic [3:0] idx, logic signed [23:0] px,
                             logic signed [23:0] py, logic [23:0] mass);
        @(negedge aclk);
        if (!no_idle && $urandom_range(99) < 21) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_entry_index = idx;
        s_pos_x = px;
        s_pos_y = py;
        s_body_mass = mass;
        if (op == OP_WRITE) n_writes++; else n_queries++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(1)) return 24'($urandom);
        return 24'(int'($urandom_range(4095)) - 2048);
    endfunction

    task automatic random_item(int query_pct);
        int               n;
        int               k;
        logic signed [23:0] px, py;
        n = (sb.body_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.body_count);
        if ($urandom_range(99) < query_pct) begin
            px = rand_coord();
            py = rand_coord();
            if (n > 0 && $urandom_range(99) < 12) begin
                k = $urandom_range(n - 1);
                px = sb.tab_x[k];
                py = sb.tab_y[k];
            end
            send_item(OP_QUERY, 4'($urandom), px, py, 24'($urandom));
        end else begin
            send_item(OP_WRITE, 4'($urandom), rand_coord(), rand_coord(),
                      $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(255)));
        end
    endtask

    initial begin
        int counts[10] = '{1, 3, 2, 16, 0, 4, 17, 31, 2, 5};
        int scales[10] = '{2000, 65535, 0, 1, -1, 40000, 2000, 300, 65535, -1};
        sb = new;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_WRITE;
        s_entry_index = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_body_mass = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_PLANET_COUNT;
        cfg_wr_data = '0;
        no_idle = 1'b0;
        stall_cycles = 0;
        n_writes = 0;
        n_queries = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, coincident bodies, capped magnitude
        write_reg(REG_PLANET_COUNT, 16'd16);
        write_reg(REG_GRAV_CONST, 16'hFFFF);
        send_item(OP_WRITE, 4'd0, 24'sh7FFFFF, 24'sh800000, 24'hFFFFFF);
        send_item(OP_WRITE, 4'd1, 24'sh800000, 24'sh7FFFFF, 24'h000000);
        send_item(OP_WRITE, 4'd2, 24'sd0, 24'sd0, 24'hFFFFFF);
        send_item(OP_WRITE, 4'd3, 24'sd1, 24'sd0, 24'hFFFFFF);
        for (int i = 4; i < TABLE_DEPTH; i++) begin
            send_item(OP_WRITE, 4'(i), rand_coord(), rand_coord(), 24'($urandom));
        end
        send_item(OP_QUERY, 4'd15, 24'sd0, 24'sd0, 24'hFFFFFF);
        send_item(OP_QUERY, 4'd0, 24'sh7FFFFF, 24'sh800000, 24'd0);
        send_item(OP_QUERY, 4'd7, 24'sh800000, 24'sh7FFFFF, 24'h5A5A5A);
        send_item(OP_QUERY, 4'd3, 24'sh7FFFFF, 24'sh7FFFFF, 24'hA5A5A5);
        send_item(OP_QUERY, 4'd9, 24'sd0, -24'sd1, 24'd0);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_PLANET_COUNT, 16'(counts[ph]));
            write_reg(REG_GRAV_CONST, scales[ph] < 0 ? 16'($urandom) : 16'(scales[ph]));
            no_idle = (ph == 1);
            if (ph == 2) -> start_hold;
            for (int j = 0; j < 183; j++) begin
                random_item(counts[ph] <= 5 ? 45 : 12);
            end
            settle();
        end

        repeat (50) @(posedge aclk);
        $display("Sent %0d body writes and %0d queries over 10 settings; checked %0d results",
                 n_writes, n_queries, sb.results);
        $display("(%0d with a coincident body, %0d saturated).", sb.n_coin, sb.n_sat);
        if (sb.errors == 0) begin
            $display("planet_gravity_acceleration verification clean");
        end else begin
            $display("planet_gravity_acceleration verification failed");
        end
        $finish;
    end
endmodule
